// ===== sv/arap_er_pkg.sv =====
package arap_er_pkg;

   localparam int ANGLE_BITS_DEFAULT  = 16;
   localparam int COORD_WIDTH_DEFAULT = 24;

   // Q14 unity for sine/cosine
   localparam logic [15:0] TRIG_ONE = 16'd16384;

   // quarter-wave polynomial coefficients, Q15
   localparam logic [31:0] POLY_A = 32'd51472;
   localparam logic [31:0] POLY_B = 32'd21024;
   localparam logic [31:0] POLY_C = 32'd2320;

   localparam logic [15:0] WEIGHT_RESET = 16'd256;

   typedef logic signed [15:0] trig_type;
   typedef logic signed [31:0] pair_type;
   typedef logic signed [45:0] term_type;
   typedef logic signed [17:0] rot_type;

   // trig lane order
   localparam int SA = 0;
   localparam int CA = 1;
   localparam int SB = 2;
   localparam int CB = 3;
   localparam int SG = 4;
   localparam int CG = 5;

   // pair product order
   localparam int P_CGCB = 0;
   localparam int P_SGCA = 1;
   localparam int P_CGSB = 2;
   localparam int P_SGSA = 3;
   localparam int P_CGCA = 4;
   localparam int P_SGSB = 5;
   localparam int P_CGSA = 6;
   localparam int P_CBSA = 7;
   localparam int P_CBCA = 8;

endpackage

// ===== sv/arap_edge_residual_core.sv =====
// ARAP edge residual pipeline. One edge transaction is accepted per clock while
// req_stall is low, and its three weighted residuals leave through the
// registered stages; throughput is one per cycle unless rsp_stall holds the
// output. The stages are the angle reduction and chained multiplies of the sine
// polynomial (five stages), the Euler matrix build (three stages) and the
// rotate, subtract, round, weight and clip steps (five stages). A held result
// only stalls the input once every stage ahead of it is full; empty stages close
// up. csr_wdata written with csr_we sets the Q8.8 edge weight (reset 1.0); write it only while the pipeline is empty.
module arap_edge_residual_core
   import arap_er_pkg::*;
#(
   parameter int ANGLE_BITS  = ANGLE_BITS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [15:0]                   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_pos_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_pos_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_b_z,
   input  logic [ANGLE_BITS-1:0]         req_angle_alpha,
   input  logic [ANGLE_BITS-1:0]         req_angle_beta,
   input  logic [ANGLE_BITS-1:0]         req_angle_gamma,
   input  logic signed [COORD_WIDTH-1:0] req_rest_edge_x,
   input  logic signed [COORD_WIDTH-1:0] req_rest_edge_y,
   input  logic signed [COORD_WIDTH-1:0] req_rest_edge_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_residual_x,
   output logic signed [31:0]            rsp_residual_y,
   output logic signed [31:0]            rsp_residual_z,
   output logic                          rsp_saturated
);

   localparam int AB = ANGLE_BITS;
   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 1;    // position difference
   localparam int EW = CW + 18;   // matrix entry times edge
   localparam int FW = CW + 21;   // difference in Q26
   localparam int RW = CW + 7;    // difference in Q12
   localparam int PW = CW + 24;   // weighted, Q20
   localparam int WW = CW + 16;   // weighted, Q12
   localparam int NS = 13;

   localparam logic [AB-1:0]        QUARTER = AB'(1) << (AB - 2);
   localparam term_type             HALF28  = term_type'(1) <<< 27;
   localparam logic signed [FW-1:0] HALF14  = FW'(1) <<< 13;
   localparam logic signed [PW-1:0] HALF8   = PW'(1) <<< 7;
   localparam logic signed [WW-1:0] RES_MAX = WW'(32'sh7FFF_FFFF);
   localparam logic signed [WW-1:0] RES_MIN = -RES_MAX - WW'(1);

   logic [NS-1:0] v_ff;
   logic [NS-1:0] move;
   logic [15:0]   weight_ff;

   // per-stage payload
   logic signed [DW-1:0] d_ff   [0:8][0:2];
   logic signed [CW-1:0] e_ff   [0:7][0:2];
   logic [15:0]          z_ff   [0:3][0:5];
   logic                 neg_ff [0:3][0:5];
   logic [15:0]          z2_ff  [1:2][0:5];
   logic [14:0]          t1_ff  [0:5];
   logic [15:0]          t2_ff  [0:5];
   trig_type             trig_ff  [0:5];
   trig_type             trig5_ff [0:2];
   pair_type             pp_ff  [0:8];
   pair_type             q3_pair_ff;
   term_type             q_ff   [0:8];
   rot_type              r_ff   [0:8];
   logic signed [EW-1:0] p_ff   [0:8];
   logic signed [FW-1:0] diff_ff [0:2];
   logic signed [RW-1:0] d12_ff  [0:2];
   logic signed [PW-1:0] wp_ff   [0:2];
   logic signed [31:0]   res_ff  [0:2];
   logic                 sat_ff;

   // next values
   logic [AB-1:0]        ang    [0:5];
   logic [AB+12:0]       zx     [0:5];
   logic [15:0]          z_in   [0:5];
   logic                 neg_in [0:5];
   logic [31:0]          z2p    [0:5];
   logic [31:0]          m2     [0:5];
   logic [31:0]          m3     [0:5];
   logic [31:0]          m4     [0:5];
   logic [15:0]          s_raw  [0:5];
   logic [15:0]          s_clip [0:5];
   logic [15:0]          z2_in  [0:5];
   logic [14:0]          t1_in  [0:5];
   logic [15:0]          t2_in  [0:5];
   trig_type             trig_in [0:5];
   pair_type             pp_in  [0:8];
   term_type             q_in   [0:8];
   rot_type              r_in   [0:8];
   logic signed [EW-1:0] p_in   [0:8];
   logic signed [FW-1:0] diff_in [0:2];
   logic signed [RW-1:0] d12_in  [0:2];
   logic signed [PW-1:0] wp_in   [0:2];
   logic signed [WW-1:0] wr      [0:2];
   logic signed [31:0]   res_in  [0:2];
   logic [2:0]           clip;
   logic signed [DW-1:0] d_in   [0:2];

   // a stage advances when empty or when the one after it advances
   always_comb begin
      move[NS-1] = !v_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         move[k] = !v_ff[k] || move[k+1];
      end
   end

   assign req_stall = !move[0];
   assign rsp_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         weight_ff <= WEIGHT_RESET;
      end else begin
         if (csr_we) begin
            weight_ff <= csr_wdata;
         end
         if (move[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (move[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage 0: angle reduction, position difference
   always_comb begin
      ang[SA] = req_angle_alpha;
      ang[CA] = req_angle_alpha + QUARTER;
      ang[SB] = req_angle_beta;
      ang[CB] = req_angle_beta + QUARTER;
      ang[SG] = req_angle_gamma;
      ang[CG] = req_angle_gamma + QUARTER;
      for (int l = 0; l < 6; l++) begin
         zx[l]     = {ang[l][AB-3:0], 15'd0};
         z_in[l]   = ang[l][AB-2] ? 16'd32768 - {1'b0, zx[l][AB+12:AB-2]}
                                  : {1'b0, zx[l][AB+12:AB-2]};
         neg_in[l] = ang[l][AB-1];
      end
      d_in[0] = DW'(req_pos_a_x) - DW'(req_pos_b_x);
      d_in[1] = DW'(req_pos_a_y) - DW'(req_pos_b_y);
      d_in[2] = DW'(req_pos_a_z) - DW'(req_pos_b_z);
   end

   // stages 1..4: quarter-wave sine polynomial
   always_comb begin
      for (int l = 0; l < 6; l++) begin
         z2p[l]    = 32'(z_ff[0][l]) * 32'(z_ff[0][l]);
         z2_in[l]  = z2p[l][30:15];
         m2[l]     = POLY_C * 32'(z2_ff[1][l]);
         t1_in[l]  = 15'(POLY_B - (m2[l] >> 15));
         m3[l]     = 32'(t1_ff[l]) * 32'(z2_ff[2][l]);
         t2_in[l]  = 16'(POLY_A - (m3[l] >> 15));
         m4[l]     = 32'(t2_ff[l]) * 32'(z_ff[3][l]);
         s_raw[l]  = m4[l][31:16];
         s_clip[l] = (s_raw[l] > TRIG_ONE) ? TRIG_ONE : s_raw[l];
         trig_in[l] = neg_ff[3][l] ? -$signed(s_clip[l]) : $signed(s_clip[l]);
      end
   end

   // stages 5..7: rotation matrix Rz*Ry*Rx
   always_comb begin
      pp_in[P_CGCB] = trig_ff[CG] * trig_ff[CB];
      pp_in[P_SGCA] = trig_ff[SG] * trig_ff[CA];
      pp_in[P_CGSB] = trig_ff[CG] * trig_ff[SB];
      pp_in[P_SGSA] = trig_ff[SG] * trig_ff[SA];
      pp_in[P_CGCA] = trig_ff[CG] * trig_ff[CA];
      pp_in[P_SGSB] = trig_ff[SG] * trig_ff[SB];
      pp_in[P_CGSA] = trig_ff[CG] * trig_ff[SA];
      pp_in[P_CBSA] = trig_ff[CB] * trig_ff[SA];
      pp_in[P_CBCA] = trig_ff[CB] * trig_ff[CA];

      q_in[0] = term_type'(pp_ff[P_CGCB]) <<< 14;
      q_in[1] = term_type'(pp_ff[P_CGSB]) * term_type'(trig5_ff[0])
              - (term_type'(pp_ff[P_SGCA]) <<< 14);
      q_in[2] = term_type'(pp_ff[P_CGSB]) * term_type'(trig5_ff[1])
              + (term_type'(pp_ff[P_SGSA]) <<< 14);
      // sin(gamma)*cos(beta) comes from its own product
      q_in[3] = term_type'(q3_pair_ff) <<< 14;
      q_in[4] = term_type'(pp_ff[P_SGSB]) * term_type'(trig5_ff[0])
              + (term_type'(pp_ff[P_CGCA]) <<< 14);
      q_in[5] = term_type'(pp_ff[P_SGSB]) * term_type'(trig5_ff[1])
              - (term_type'(pp_ff[P_CGSA]) <<< 14);
      q_in[6] = -(term_type'(trig5_ff[2]) <<< 28);
      q_in[7] = term_type'(pp_ff[P_CBSA]) <<< 14;
      q_in[8] = term_type'(pp_ff[P_CBCA]) <<< 14;

      for (int k = 0; k < 9; k++) begin
         r_in[k] = rot_type'((q_ff[k] + HALF28) >>> 28);
      end
   end

   // stages 8..12: rotate edge, subtract, round, weight, clip
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p_in[3*i+j] = EW'(r_ff[3*i+j]) * EW'(e_ff[7][j]);
         end
         diff_in[i] = (FW'(d_ff[8][i]) <<< 14) - FW'(p_ff[3*i]) - FW'(p_ff[3*i+1])
                    - FW'(p_ff[3*i+2]);
         d12_in[i]  = RW'((diff_ff[i] + HALF14) >>> 14);
         wp_in[i]   = PW'(d12_ff[i]) * PW'($signed({1'b0, weight_ff}));
         wr[i]      = WW'((wp_ff[i] + HALF8) >>> 8);
         if (wr[i] > RES_MAX) begin
            res_in[i] = 32'sh7FFF_FFFF;
            clip[i]   = 1'b1;
         end else if (wr[i] < RES_MIN) begin
            res_in[i] = -32'sh7FFF_FFFF - 32'sd1;
            clip[i]   = 1'b1;
         end else begin
            res_in[i] = wr[i][31:0];
            clip[i]   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         d_ff[0][0] <= d_in[0];
         d_ff[0][1] <= d_in[1];
         d_ff[0][2] <= d_in[2];
         e_ff[0][0] <= req_rest_edge_x;
         e_ff[0][1] <= req_rest_edge_y;
         e_ff[0][2] <= req_rest_edge_z;
         z_ff[0]    <= z_in;
         neg_ff[0]  <= neg_in;
      end
      for (int k = 1; k < 9; k++) begin
         if (move[k]) begin
            d_ff[k] <= d_ff[k-1];
         end
      end
      for (int k = 1; k < 8; k++) begin
         if (move[k]) begin
            e_ff[k] <= e_ff[k-1];
         end
      end
      for (int k = 1; k < 4; k++) begin
         if (move[k]) begin
            z_ff[k]   <= z_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
      if (move[1]) begin
         z2_ff[1] <= z2_in;
      end
      if (move[2]) begin
         z2_ff[2] <= z2_ff[1];
         t1_ff    <= t1_in;
      end
      if (move[3]) begin
         t2_ff <= t2_in;
      end
      if (move[4]) begin
         trig_ff <= trig_in;
      end
      if (move[5]) begin
         pp_ff       <= pp_in;
         trig5_ff[0] <= trig_ff[SA];
         trig5_ff[1] <= trig_ff[CA];
         trig5_ff[2] <= trig_ff[SB];
         q3_pair_ff  <= trig_ff[SG] * trig_ff[CB];
      end
      if (move[6]) begin
         q_ff <= q_in;
      end
      if (move[7]) begin
         r_ff <= r_in;
      end
      if (move[8]) begin
         p_ff <= p_in;
      end
      if (move[9]) begin
         diff_ff <= diff_in;
      end
      if (move[10]) begin
         d12_ff <= d12_in;
      end
      if (move[11]) begin
         wp_ff <= wp_in;
      end
      if (move[12]) begin
         res_ff <= res_in;
         sat_ff <= |clip;
      end
   end

   assign rsp_residual_x = res_ff[0];
   assign rsp_residual_y = res_ff[1];
   assign rsp_residual_z = res_ff[2];
   assign rsp_saturated  = sat_ff;

endmodule

// ===== tb/tb_arap_edge_residual_core.sv =====
module tb_arap_edge_residual_core;
   import arap_er_pkg::*;

   localparam int AW = 16;
   localparam int CW = 24;

   typedef struct {
      logic signed [CW-1:0] pa [3];
      logic signed [CW-1:0] pb [3];
      logic [AW-1:0]        ang [3];
      logic signed [CW-1:0] re [3];
   } edge_type;

   typedef struct {
      logic signed [31:0] res [3];
      logic               sat;
   } resid_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [15:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [CW-1:0] req_pos_a_x = '0, req_pos_a_y = '0, req_pos_a_z = '0;
   logic signed [CW-1:0] req_pos_b_x = '0, req_pos_b_y = '0, req_pos_b_z = '0;
   logic [AW-1:0] req_angle_alpha = '0, req_angle_beta = '0, req_angle_gamma = '0;
   logic signed [CW-1:0] req_rest_edge_x = '0, req_rest_edge_y = '0, req_rest_edge_z = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_residual_x, rsp_residual_y, rsp_residual_z;
   logic rsp_saturated;

   arap_edge_residual_core #(.ANGLE_BITS(AW), .COORD_WIDTH(CW)) dut (.*);

   edge_type  pending_edges [$];
   resid_type expected_resids [$];
   logic [15:0] weight_model;
   int errors = 0;
   int gap_cnt = 0;
   int stall_cnt = 0;
   bit drain_hold = 0;

   initial forever #4 clock = ~clock;

   function automatic longint rnd_sh(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint quarter_sin(longint z);
      longint z2, t;
      z2 = (z * z) >> 15;
      t = (2320 * z2) >> 15;
      t = 21024 - t;
      t = (t * z2) >> 15;
      t = 51472 - t;
      t = (t * z) >> 15;
      t = t >> 1;
      if (t > 16384) t = 16384;
      return t;
   endfunction

   function automatic longint bam_sin(logic [AW-1:0] a);
      int quad;
      longint z, s;
      quad = a[AW-1 -: 2];
      z = longint'(a[AW-3:0]) << (17 - AW);
      if (quad[0]) z = 32768 - z;
      s = quarter_sin(z);
      return quad[1] ? -s : s;
   endfunction

   function automatic longint bam_cos(logic [AW-1:0] a);
      logic [AW-1:0] b;
      b = a + (1 << (AW - 2));
      return bam_sin(b);
   endfunction

   function automatic resid_type edge_residual(edge_type it, logic [15:0] w);
      resid_type o;
      longint sa, ca, sb, cb, sg, cg, rot, diff, d12, wv;
      longint m [9];
      longint one;
      one = 16384;
      sa = bam_sin(it.ang[0]); ca = bam_cos(it.ang[0]);
      sb = bam_sin(it.ang[1]); cb = bam_cos(it.ang[1]);
      sg = bam_sin(it.ang[2]); cg = bam_cos(it.ang[2]);
      m[0] = rnd_sh(cg * cb * one, 28);
      m[1] = rnd_sh(-sg * ca * one + cg * sb * sa, 28);
      m[2] = rnd_sh(sg * sa * one + cg * sb * ca, 28);
      m[3] = rnd_sh(sg * cb * one, 28);
      m[4] = rnd_sh(cg * ca * one + sg * sb * sa, 28);
      m[5] = rnd_sh(-cg * sa * one + sg * sb * ca, 28);
      m[6] = rnd_sh(-sb * one * one, 28);
      m[7] = rnd_sh(cb * sa * one, 28);
      m[8] = rnd_sh(cb * ca * one, 28);
      o.sat = 0;
      for (int i = 0; i < 3; i++) begin
         rot = m[3*i] * longint'(it.re[0]) + m[3*i+1] * longint'(it.re[1])
             + m[3*i+2] * longint'(it.re[2]);
         diff = (longint'(it.pa[i]) - longint'(it.pb[i])) * one - rot;
         d12 = rnd_sh(diff, 14);
         wv = rnd_sh(d12 * longint'({1'b0, w}), 8);
         if (wv > 64'sd2147483647) begin
            wv = 64'sd2147483647; o.sat = 1;
         end else if (wv < -64'sd2147483648) begin
            wv = -64'sd2147483648; o.sat = 1;
         end
         o.res[i] = wv[31:0];
      end
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return {1'b0, {(CW-1){1'b1}}};
      if (r == 1) return {1'b1, {(CW-1){1'b0}}};
      if (r < 5) return $signed(CW'($urandom_range(0, 65535))) - 32768;
      return CW'($urandom);
   endfunction

   function automatic edge_type rand_edge();
      edge_type it;
      for (int i = 0; i < 3; i++) begin
         it.pa[i] = rand_coord();
         it.pb[i] = rand_coord();
         it.re[i] = rand_coord();
         it.ang[i] = ($urandom_range(0, 7) == 0) ? AW'($urandom_range(0, 3) << (AW - 2))
                                                 : AW'($urandom);
      end
      return it;
   endfunction

   // driver: the head of the queue is the transaction on the bus until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_resids.push_back(edge_residual(pending_edges[0], weight_model));
            void'(pending_edges.pop_front());
         end
         if (gap_cnt > 0) begin
            gap_cnt <= gap_cnt - 1;
            req_valid <= 0;
         end else if (!drain_hold && pending_edges.size() > 0) begin
            edge_type it;
            it = pending_edges[0];
            req_valid <= 1;
            {req_pos_a_x, req_pos_a_y, req_pos_a_z} <= {it.pa[0], it.pa[1], it.pa[2]};
            {req_pos_b_x, req_pos_b_y, req_pos_b_z} <= {it.pb[0], it.pb[1], it.pb[2]};
            {req_angle_alpha, req_angle_beta, req_angle_gamma} <=
               {it.ang[0], it.ang[1], it.ang[2]};
            {req_rest_edge_x, req_rest_edge_y, req_rest_edge_z} <=
               {it.re[0], it.re[1], it.re[2]};
            gap_cnt <= pick_gap();
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_resids.size() == 0) begin
               $error("result transaction with nothing expected");
               errors++;
            end else begin
               resid_type e;
               e = expected_resids.pop_front();
               if (rsp_residual_x !== e.res[0]) begin
                  $error("residual_x exp %0d got %0d", e.res[0], rsp_residual_x); errors++;
               end
               if (rsp_residual_y !== e.res[1]) begin
                  $error("residual_y exp %0d got %0d", e.res[1], rsp_residual_y); errors++;
               end
               if (rsp_residual_z !== e.res[2]) begin
                  $error("residual_z exp %0d got %0d", e.res[2], rsp_residual_z); errors++;
               end
               if (rsp_saturated !== e.sat) begin
                  $error("saturated exp %0b got %0b", e.sat, rsp_saturated); errors++;
               end
            end
         end
         if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            stall_cnt <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         end
      end
   end

   task automatic wait_drained();
      while (pending_edges.size() != 0 || req_valid || expected_resids.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_weight(logic [15:0] w);
      csr_we <= 1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we <= 0;
      weight_model = w;
   endtask

   initial begin
      edge_type it;
      logic [15:0] weights [5];
      weights = '{16'hFFFF, 16'd0, 16'd1, 16'd700, 16'd256};
      weight_model = WEIGHT_RESET;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero, extremes, quadrant angles at reset weight, then saturation at full weight
      for (int k = 0; k < 20; k++) begin
         it = rand_edge();
         for (int i = 0; i < 3; i++) begin
            case (k % 4)
               0: begin it.pa[i] = '0; it.pb[i] = '0; it.re[i] = '0; end
               1: begin
                  it.pa[i] = {1'b0, {(CW-1){1'b1}}}; it.pb[i] = {1'b1, {(CW-1){1'b0}}};
                  it.re[i] = {1'b1, {(CW-1){1'b0}}};
               end
               2: begin
                  it.pa[i] = {1'b1, {(CW-1){1'b0}}}; it.pb[i] = {1'b0, {(CW-1){1'b1}}};
                  it.re[i] = {1'b0, {(CW-1){1'b1}}};
               end
               default: ;
            endcase
            it.ang[i] = (k < 16) ? AW'((k + i) % 4 << (AW - 2)) : {AW{1'b1}};
         end
         pending_edges.push_back(it);
      end
      wait_drained();
      write_weight(16'hFFFF);
      for (int k = 0; k < 5; k++) begin
         it = rand_edge();
         it.pa[0] = {1'b0, {(CW-1){1'b1}}}; it.pb[0] = {1'b1, {(CW-1){1'b0}}};
         pending_edges.push_back(it);
      end
      wait_drained();

      foreach (weights[p]) begin
         write_weight(weights[p]);
         for (int k = 0; k < 105; k++) pending_edges.push_back(rand_edge());
         // sender holds until the pipe is empty partway through
         while (pending_edges.size() > 50) @(posedge clock);
         drain_hold = 1;
         while (expected_resids.size() != 0 || req_valid) @(posedge clock);
         drain_hold = 0;
         wait_drained();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
